/* rtl/fcik_pkg.sv */
// ----------------------------------------------------------------------------
// fcik_pkg: shared types and constants
// Transaction payload structs and fixed datapath widths for the four-cable
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fcik_pkg;

    localparam int COORD_W    = 24;
    localparam int INSET_W    = 16;
    localparam int SPM_W      = 24;
    localparam int STEPS_W    = 31;
    localparam int PEN_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Anchor coordinate, difference and magnitude widths.
    localparam int ANCHOR_W = COORD_W + 1;
    localparam int DIFF_W   = COORD_W + 2;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int D2_W     = 52;

    // Square root: radicand is D2 with 12 extra fraction bits.
    localparam int DIST_EXTRA = 6;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;
    localparam int PROD_W     = ROOT_W + SPM_W;

    // Register stages in one lane: abs diff, square, sum, root, multiply, round.
    localparam int LANE_LAT = 3 + ROOT_W + 2;

    localparam logic [STEPS_W-1:0] STEP_MAX = {STEPS_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_INSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic signed [COORD_W-1:0] z_pos;
    } t_in_item;

    typedef struct packed {
        logic        [STEPS_W-1:0] top_left_steps;
        logic        [STEPS_W-1:0] top_right_steps;
        logic        [STEPS_W-1:0] bottom_right_steps;
        logic        [STEPS_W-1:0] bottom_left_steps;
        logic signed [PEN_W-1:0]   pen_value;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/fcik_isqrt.sv */
// ----------------------------------------------------------------------------
// fcik_isqrt: pipelined integer square root
// One root bit per register stage, restoring digit recurrence, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module fcik_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [fcik_pkg::RAD_W-1:0]  i_rad,
    output logic      [fcik_pkg::ROOT_W-1:0] o_root
);
    import fcik_pkg::*;

    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [RAD_W-1:0]  w_rad_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [REM_W:0]    w_rem_sh;
        logic [REM_W:0]    w_trial;
        logic [RAD_W-1:0]  n_rad;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rad_in  = i_rad;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rad_in  = r_rad[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        always_comb begin
            // Bring down the next two radicand bits and try root*4+1.
            w_rem_sh = {w_rem_in[REM_W-2:0], w_rad_in[RAD_W-1 -: 2]};
            w_trial  = {1'b0, w_root_in, 2'b01};
            n_rad    = {w_rad_in[RAD_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                n_rem  = REM_W'(w_rem_sh - w_trial);
                n_root = {w_root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rem_sh[REM_W-1:0];
                n_root = {w_root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= n_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/fcik_lane.sv */
// ----------------------------------------------------------------------------
// fcik_lane: belt length for one anchor
// Distance from anchor to point, scaled to motor steps, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module fcik_lane #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [fcik_pkg::COORD_W-1:0]  i_px,
    input  wire logic signed [fcik_pkg::COORD_W-1:0]  i_py,
    input  wire logic signed [fcik_pkg::ANCHOR_W-1:0] i_ax,
    input  wire logic signed [fcik_pkg::ANCHOR_W-1:0] i_ay,
    input  wire logic        [fcik_pkg::SPM_W-1:0]    i_steps_per_mm,
    output logic             [fcik_pkg::STEPS_W-1:0]  o_steps
);
    import fcik_pkg::*;

    localparam int SH = COORD_FRAC_BITS + DIST_EXTRA + 16;

    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic [DIFF_W-1:0]        r_ux;
    logic [DIFF_W-1:0]        r_uy;
    logic [SQ_W-1:0]          r_sqx;
    logic [SQ_W-1:0]          r_sqy;
    logic [D2_W-1:0]          r_d2;
    logic [ROOT_W-1:0]        w_dist;
    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W:0]          w_rnd;
    logic [PROD_W:0]          w_shift;
    logic [STEPS_W-1:0]       r_steps;

    assign w_dx = DIFF_W'(i_px) - DIFF_W'(i_ax);
    assign w_dy = DIFF_W'(i_py) - DIFF_W'(i_ay);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux  <= w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
            r_uy  <= w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
            r_sqx <= r_ux * r_ux;
            r_sqy <= r_uy * r_uy;
            r_d2  <= D2_W'(r_sqx + r_sqy);
        end
    end

    fcik_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  ({r_d2, (2 * DIST_EXTRA)'(0)}),
        .o_root (w_dist)
    );

    assign w_rnd   = (PROD_W + 1)'(r_prod) + ((PROD_W + 1)'(1) << (SH - 1));
    assign w_shift = w_rnd >> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(w_dist * i_steps_per_mm);
            r_steps <= (w_shift > (PROD_W + 1)'(STEP_MAX)) ? STEP_MAX
                                                           : w_shift[STEPS_W-1:0];
        end
    end

    assign o_steps = r_steps;

endmodule

`default_nettype wire

/* rtl/four_cable_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// four_cable_inverse_kinematics: belt lengths for a four-cable plotter
// Converts a pen position into four anchor belt lengths in motor steps.
// ----------------------------------------------------------------------------
// Each input transaction carries a pen position (x, y, z) in signed fixed
// point with COORD_FRAC_BITS fraction bits. The block returns one output
// transaction per input with the belt length, in motor steps, from each of
// the four anchors (the configured axis limits pulled inward by the corner
// inset) and the z value truncated toward zero to whole millimeters. A new
// transaction can be accepted every clock cycle while the pipeline is not
// held; each one passes through the 32-stage square root (one root bit per
// stage) plus the difference, square, sum, multiply and rounding stages. The
// whole pipeline advances together and holds when the output register is
// full and stalled. Configuration is written through a plain write port and
// must only change while the pipeline is empty.
`default_nettype none

module four_cable_inverse_kinematics #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration write port.
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [fcik_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [fcik_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // Input transaction channel.
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire fcik_pkg::t_in_item                     i_in_data,
    // Output transaction channel.
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output fcik_pkg::t_out_item                         o_out_data
);
    import fcik_pkg::*;

    localparam int LAT = LANE_LAT;

    // Configuration registers.
    logic signed [COORD_W-1:0] r_x_min;
    logic signed [COORD_W-1:0] r_x_max;
    logic signed [COORD_W-1:0] r_y_min;
    logic signed [COORD_W-1:0] r_y_max;
    logic [INSET_W-1:0]        r_inset;
    logic [SPM_W-1:0]          r_spm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= -COORD_W'(76800);
            r_x_max <= COORD_W'(76800);
            r_y_min <= -COORD_W'(76800);
            r_y_max <= COORD_W'(76800);
            r_inset <= '0;
            r_spm   <= SPM_W'(5242880);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_X_MIN:        r_x_min <= i_cfg_wdata;
                CFG_X_MAX:        r_x_max <= i_cfg_wdata;
                CFG_Y_MIN:        r_y_min <= i_cfg_wdata;
                CFG_Y_MAX:        r_y_max <= i_cfg_wdata;
                CFG_CORNER_INSET: r_inset <= i_cfg_wdata[INSET_W-1:0];
                CFG_STEPS_PER_MM: r_spm   <= i_cfg_wdata[SPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Anchor coordinates; the inset may push an anchor past the opposite limit.
    logic signed [ANCHOR_W-1:0] w_left;
    logic signed [ANCHOR_W-1:0] w_right;
    logic signed [ANCHOR_W-1:0] w_top;
    logic signed [ANCHOR_W-1:0] w_bottom;
    logic signed [ANCHOR_W-1:0] w_inset;

    assign w_inset  = ANCHOR_W'(r_inset);
    assign w_left   = ANCHOR_W'(r_x_min) + w_inset;
    assign w_right  = ANCHOR_W'(r_x_max) - w_inset;
    assign w_top    = ANCHOR_W'(r_y_max) - w_inset;
    assign w_bottom = ANCHOR_W'(r_y_min) + w_inset;

    // The pipeline moves whenever the output register is free or being drained.
    logic           w_en;
    logic [LAT-1:0] r_valid;

    assign w_en       = !r_valid[LAT-1] || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[LAT-2:0], i_in_valid};
        end
    end

    // Pen value: magnitude truncated to whole millimeters, sign restored,
    // then clamped to the 16-bit signed range.
    logic [COORD_W-1:0]      w_zmag;
    logic [COORD_W-1:0]      w_zq;
    logic signed [PEN_W-1:0] w_pen;
    logic signed [PEN_W-1:0] r_pen [LAT];

    assign w_zmag = i_in_data.z_pos[COORD_W-1] ? COORD_W'(-i_in_data.z_pos)
                                               : COORD_W'(i_in_data.z_pos);
    assign w_zq   = w_zmag >> COORD_FRAC_BITS;

    always_comb begin
        if (i_in_data.z_pos[COORD_W-1]) begin
            w_pen = (w_zq > COORD_W'(32768)) ? PEN_W'(-32768) : PEN_W'(-w_zq);
        end else begin
            w_pen = (w_zq > COORD_W'(32767)) ? PEN_W'(32767) : w_zq[PEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pen[0] <= w_pen;
            for (int k = 1; k < LAT; k++) begin
                r_pen[k] <= r_pen[k-1];
            end
        end
    end

    // One lane per anchor.
    logic [STEPS_W-1:0] w_tl;
    logic [STEPS_W-1:0] w_tr;
    logic [STEPS_W-1:0] w_br;
    logic [STEPS_W-1:0] w_bl;

    fcik_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_tl (
        .i_clk(i_clk), .i_en(w_en), .i_px(i_in_data.x_pos), .i_py(i_in_data.y_pos),
        .i_ax(w_left), .i_ay(w_top), .i_steps_per_mm(r_spm), .o_steps(w_tl)
    );

    fcik_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_tr (
        .i_clk(i_clk), .i_en(w_en), .i_px(i_in_data.x_pos), .i_py(i_in_data.y_pos),
        .i_ax(w_right), .i_ay(w_top), .i_steps_per_mm(r_spm), .o_steps(w_tr)
    );

    fcik_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_br (
        .i_clk(i_clk), .i_en(w_en), .i_px(i_in_data.x_pos), .i_py(i_in_data.y_pos),
        .i_ax(w_right), .i_ay(w_bottom), .i_steps_per_mm(r_spm), .o_steps(w_br)
    );

    fcik_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_bl (
        .i_clk(i_clk), .i_en(w_en), .i_px(i_in_data.x_pos), .i_py(i_in_data.y_pos),
        .i_ax(w_left), .i_ay(w_bottom), .i_steps_per_mm(r_spm), .o_steps(w_bl)
    );

    // All output fields come straight from the last register stage.
    assign o_out_valid                   = r_valid[LAT-1];
    assign o_out_data.top_left_steps     = w_tl;
    assign o_out_data.top_right_steps    = w_tr;
    assign o_out_data.bottom_right_steps = w_br;
    assign o_out_data.bottom_left_steps  = w_bl;
    assign o_out_data.pen_value          = r_pen[LAT-1];

    // An accepted input transaction always lands in the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_valid[0])
        else $error("accepted transaction did not enter the pipeline");

    // A held pipeline keeps every stage's valid bit.
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_valid))
        else $error("pipeline valid bits moved during a stall");

    // An empty second-to-last stage leaves no result to present.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_valid[LAT-2]) |=> !o_out_valid)
        else $error("output valid without a transaction behind it");

endmodule

`default_nettype wire
